// ----- src/prq_pkg.sv -----
// Shared types and codes for the priority ring event queue.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package prq_pkg;

	// command codes; the fourth code means nothing and leaves the queue alone
	localparam logic [1:0] CMD_PUSH_BACK  = 2'd0;
	localparam logic [1:0] CMD_PUSH_FRONT = 2'd1;
	localparam logic [1:0] CMD_POP        = 2'd2;

	localparam int TYPE_W    = 16;
	localparam int PARAM_W   = 16;
	localparam int HANDLER_W = 8;
	localparam int WORD_W    = 32;
	localparam int FILL_W    = 5;

	typedef struct packed {
		logic [TYPE_W-1:0]    sig_type;
		logic [PARAM_W-1:0]   sig_param;
		logic [HANDLER_W-1:0] handler_id;
		logic [WORD_W-1:0]    data_word;
	} prq_entry_t;

	localparam int ENTRY_W = $bits(prq_entry_t);

	// per-item status that travels next to the popped entry
	typedef struct packed {
		logic              entry_valid;
		logic              overwrote;
		logic [FILL_W-1:0] fill_count;
	} prq_status_t;

endpackage

`default_nettype wire

// ----- src/prq_ifs.sv -----
// Valid/ready channel interfaces for command items and result items.
// Depends on prq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface prq_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       command;
	logic [prq_pkg::TYPE_W-1:0]       sig_type;
	logic [prq_pkg::PARAM_W-1:0]      sig_param;
	logic [prq_pkg::HANDLER_W-1:0]    handler_id;
	logic [prq_pkg::WORD_W-1:0]       data_word;

	modport source (output valid, command, sig_type, sig_param, handler_id, data_word,
		input ready);
	modport sink (input valid, command, sig_type, sig_param, handler_id, data_word,
		output ready);
endinterface

interface prq_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             entry_valid;
	logic [prq_pkg::TYPE_W-1:0]       out_type;
	logic [prq_pkg::PARAM_W-1:0]      out_param;
	logic [prq_pkg::HANDLER_W-1:0]    out_handler;
	logic [prq_pkg::WORD_W-1:0]       out_word;
	logic                             overwrote;
	logic [prq_pkg::FILL_W-1:0]       fill_count;

	modport source (output valid, entry_valid, out_type, out_param, out_handler, out_word,
		overwrote, fill_count, input ready);
	modport sink (input valid, entry_valid, out_type, out_param, out_handler, out_word,
		overwrote, fill_count, output ready);
endinterface

`default_nettype wire

// ----- src/prq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module prq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- src/prq_ctrl.sv -----
// Front/back pointers and fill count; decodes one command per accepted item.
// Depends on prq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prq_ctrl #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire logic [1:0]                     command,
	output logic                                wr_en,
	output logic [$clog2(QUEUE_DEPTH)-1:0]      wr_addr,
	output logic                                rd_en,
	output logic [$clog2(QUEUE_DEPTH)-1:0]      rd_addr,
	output prq_pkg::prq_status_t                status
);
	import prq_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [IDX_W-1:0] FRONT_RST = IDX_W'(1 % QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	logic [IDX_W-1:0] front_q, front_d, back_q, back_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] front_inc, front_dec, back_inc, back_dec;
	logic             full;

	assign full      = (count_q == CNT_FULL);
	assign front_inc = (front_q == IDX_LAST) ? '0 : front_q + IDX_W'(1);
	assign front_dec = (front_q == '0) ? IDX_LAST : front_q - IDX_W'(1);
	assign back_inc  = (back_q == IDX_LAST) ? '0 : back_q + IDX_W'(1);
	assign back_dec  = (back_q == '0) ? IDX_LAST : back_q - IDX_W'(1);
	assign rd_addr   = front_q;

	always_comb begin
		front_d            = front_q;
		back_d             = back_q;
		count_d            = count_q;
		wr_en              = 1'b0;
		wr_addr            = back_q;
		rd_en              = 1'b0;
		status.entry_valid = 1'b0;
		status.overwrote   = 1'b0;
		unique case (command)
			CMD_PUSH_BACK: begin
				// full: newest entry is replaced in place
				wr_en            = accept;
				status.overwrote = full;
				if (!full) begin
					back_d  = back_inc;
					count_d = count_q + CNT_W'(1);
				end
				wr_addr = back_d;
			end
			CMD_PUSH_FRONT: begin
				// full: newest entry drops off the back
				wr_en            = accept;
				wr_addr          = front_dec;
				front_d          = front_dec;
				status.overwrote = full;
				if (full) begin
					back_d = back_dec;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_POP: begin
				if (count_q != '0) begin
					rd_en              = accept;
					status.entry_valid = 1'b1;
					front_d            = front_inc;
					count_d            = count_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
		status.fill_count = FILL_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= FRONT_RST;
			back_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/priority_ring_event_queue.sv -----
// Top level of the priority ring event queue: pointer control, entry RAM,
// result register. Depends on prq_pkg, prq_ifs, prq_ram and prq_ctrl.
//
// Usage:
//  - queue_req carries one command item: push at back, priority push at
//    front, or pop from front, with the entry fields used by the pushes.
//  - queue_rsp returns exactly one result item per command, in order: the
//    popped entry (zeros when nothing was popped), the overwrite flag, and
//    the fill count after the command (low five bits).
//  - Path: a result passes through the RAM read register (with the stage 1
//    status) and then the result register before it shows on queue_rsp.
//  - Throughput: one item per cycle while queue_rsp is not held. Pointers and
//    count update at the accept edge; the RAM takes at most one access per item.
//  - Stalls: while queue_rsp is held and a second result waits behind it,
//    queue_req.ready drops; no item is lost or repeated.
//  - Reset: arst_n clears pointers (front 1, back 0), the count and all valid
//    flags at once. The entry RAM is not cleared; a pop only reads entries
//    that were written, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module priority_ring_event_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	prq_cmd_if.sink    queue_req,
	prq_rsp_if.source  queue_rsp
);
	import prq_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	logic             accept;
	logic             advance;
	logic             wr_en, rd_en;
	logic [IDX_W-1:0] wr_addr, rd_addr;
	prq_entry_t       wr_entry, rd_entry;
	prq_status_t      status;

	// stage 1: status beside the RAM read register
	logic        valid_s1;
	prq_status_t status_s1;

	// result register
	logic        rsp_valid_q;
	prq_status_t status_q;
	prq_entry_t  entry_q;

	assign advance         = valid_s1 && (!rsp_valid_q || queue_rsp.ready);
	assign queue_req.ready = !valid_s1 || advance;
	assign accept          = queue_req.valid && queue_req.ready;

	assign wr_entry.sig_type   = queue_req.sig_type;
	assign wr_entry.sig_param  = queue_req.sig_param;
	assign wr_entry.handler_id = queue_req.handler_id;
	assign wr_entry.data_word  = queue_req.data_word;

	prq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.command (queue_req.command),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.status  (status)
	);

	// read data holds while stage 1 stalls: no read is issued then
	prq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (queue_rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
		end
		if (advance) begin
			status_q <= status_s1;
			entry_q  <= status_s1.entry_valid ? rd_entry : '0;
		end
	end

	assign queue_rsp.valid       = rsp_valid_q;
	assign queue_rsp.entry_valid = status_q.entry_valid;
	assign queue_rsp.overwrote   = status_q.overwrote;
	assign queue_rsp.fill_count  = status_q.fill_count;
	assign queue_rsp.out_type    = entry_q.sig_type;
	assign queue_rsp.out_param   = entry_q.sig_param;
	assign queue_rsp.out_handler = entry_q.handler_id;
	assign queue_rsp.out_word    = entry_q.data_word;

endmodule

`default_nettype wire

// ----- src/prq_checker.sv -----
// Port-level checks for the priority ring event queue, bound to the top level.
// Depends on prq_pkg and priority_ring_event_queue.
`timescale 1ns / 1ps
`default_nettype none

module prq_checker #(
	parameter int QUEUE_DEPTH = 16
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_ready,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic                          entry_valid,
	input wire logic                          overwrote,
	input wire logic [prq_pkg::FILL_W-1:0]    fill_count,
	input wire logic [prq_pkg::WORD_W-1:0]    out_word
);
	import prq_pkg::*;

	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

	// a held result stays put until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_word) && $stable(fill_count))
		else $error("result changed while stalled");

	// with the result register empty the block must take commands
	assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("input stalled with empty result register");

	// an overwrite only happens on a push into a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && overwrote |-> !entry_valid && fill_count == FILL_FULL)
		else $error("overwrite reported without a full queue");

	// a popped entry never leaves the queue full
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && entry_valid |-> fill_count != FILL_FULL)
		else $error("pop reported a full count");

endmodule

bind priority_ring_event_queue prq_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_prq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_ready   (queue_req.ready),
	.rsp_valid   (queue_rsp.valid),
	.rsp_ready   (queue_rsp.ready),
	.entry_valid (queue_rsp.entry_valid),
	.overwrote   (queue_rsp.overwrote),
	.fill_count  (queue_rsp.fill_count),
	.out_word    (queue_rsp.out_word)
);

`default_nettype wire

// ----- test/tb_priority_ring_event_queue.sv -----
// Testbench for priority_ring_event_queue: directed corners, random command traffic
// under three idle patterns, and a long output stall. Needs prq_pkg, prq_ifs and the RTL.
`timescale 1ns / 1ps

module tb_priority_ring_event_queue;
	import prq_pkg::*;

	localparam int DEPTH = 16;
	// the unused command code; the queue must leave itself alone
	localparam logic [1:0] CMD_NONE = 2'd3;
	// margin wait after the drain loop, past the RAM read and result registers
	localparam int LATENCY_CYCLES = 8;
	localparam int MAX_REPORTS = 10;

	// one predicted result item
	typedef struct packed {
		logic       entry_valid;
		prq_entry_t entry;
		logic       overwrote;
		logic [FILL_W-1:0] fill_count;
	} queue_result_t;

	logic clk = 1'b0;
	logic arst_n;

	always #5 clk = ~clk;

	prq_cmd_if req_ch ();
	prq_rsp_if rsp_ch ();

	priority_ring_event_queue #(
		.QUEUE_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.queue_req(req_ch),
		.queue_rsp(rsp_ch)
	);

	// ---------------------------------------------------------------
	// Shadow copy of the ring. Pointers and count follow the block's
	// reset values: front 1, back 0, empty.
	// ---------------------------------------------------------------
	prq_entry_t ring_entry [DEPTH];
	int head_slot = 1 % DEPTH;
	int tail_slot = 0;
	int occupancy = 0;

	queue_result_t predicted_results [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	// long output stall, counted down by the receiver process
	int hold_left = 0;
	int mismatch_count = 0;

	// Applies one command to the shadow ring and returns the item the block should give.
	function automatic queue_result_t apply_event_command(logic [1:0] cmd, prq_entry_t e);
		queue_result_t r;
		bit full;
		r = '0;
		full = (occupancy >= DEPTH);
		case (cmd)
			CMD_PUSH_BACK: begin
				// full: the newest entry is overwritten in place
				if (!full) begin
					tail_slot = (tail_slot + 1) % DEPTH;
					occupancy++;
				end
				ring_entry[tail_slot] = e;
				r.overwrote = full;
			end
			CMD_PUSH_FRONT: begin
				// full: the newest entry drops off the back to make room at the front
				head_slot = (head_slot + DEPTH - 1) % DEPTH;
				if (full)
					tail_slot = (tail_slot + DEPTH - 1) % DEPTH;
				ring_entry[head_slot] = e;
				if (!full)
					occupancy++;
				r.overwrote = full;
			end
			CMD_POP: begin
				// empty: nothing changes and the entry fields stay zero
				if (occupancy > 0) begin
					r.entry_valid = 1'b1;
					r.entry = ring_entry[head_slot];
					head_slot = (head_slot + 1) % DEPTH;
					occupancy--;
				end
			end
			default: ;
		endcase
		r.fill_count = FILL_W'(occupancy);
		return r;
	endfunction

	// Field value biased toward the extremes now and then.
	function automatic prq_entry_t random_entry();
		prq_entry_t e;
		int unsigned pick;
		e.sig_type = 16'($urandom);
		e.sig_param = 16'($urandom);
		e.handler_id = 8'($urandom);
		e.data_word = $urandom;
		pick = $urandom_range(9);
		if (pick == 0)
			e = '0;
		else if (pick == 1)
			e = '1;
		return e;
	endfunction

	// Offers one item, holds it until accepted, then records the prediction.
	task automatic send_item(input logic [1:0] cmd, input prq_entry_t e);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.sig_type <= e.sig_type;
		req_ch.sig_param <= e.sig_param;
		req_ch.handler_id <= e.handler_id;
		req_ch.data_word <= e.data_word;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted_results.push_back(apply_event_command(cmd, e));
	endtask

	// Empty and full corners, every command, the unused code, both overwrite kinds.
	task automatic test_directed_corners();
		int i;
		send_item(CMD_POP, random_entry());
		send_item(CMD_NONE, '1);
		send_item(CMD_PUSH_BACK, '0);
		send_item(CMD_PUSH_FRONT, '1);
		send_item(CMD_POP, '1);
		send_item(CMD_POP, '0);
		send_item(CMD_POP, '1);
		// fill to the top from both ends
		for (i = 0; i < DEPTH; i++)
			send_item((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, random_entry());
		send_item(CMD_PUSH_BACK, random_entry());
		send_item(CMD_PUSH_FRONT, random_entry());
		send_item(CMD_NONE, random_entry());
		send_item(CMD_POP, random_entry());
	endtask

	// Bursts that lean toward pushes or pops so the fill level sweeps empty to full.
	task automatic test_random_traffic(input int n_items);
		int sent;
		int burst_left;
		int unsigned push_pct;
		int unsigned roll;
		logic [1:0] cmd;
		sent = 0;
		burst_left = 0;
		push_pct = 50;
		while (sent < n_items) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(40, 8);
				case ($urandom_range(2))
					0: push_pct = 80;
					1: push_pct = 20;
					default: push_pct = 50;
				endcase
			end
			roll = $urandom_range(99);
			if (roll < 4)
				cmd = CMD_NONE;
			else if ($urandom_range(99) < push_pct)
				cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
			else
				cmd = CMD_POP;
			send_item(cmd, random_entry());
			burst_left--;
			sent++;
		end
	endtask

	// Receiver holds off for a long stretch while pushes keep coming, so
	// results back up and the block has to drop its input ready.
	task automatic test_full_backpressure();
		int i;
		int unsigned saved_pct;
		saved_pct = send_idle_pct;
		send_idle_pct = 0;
		hold_left = 300;
		for (i = 0; i < 40; i++)
			send_item((i % 3 == 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, random_entry());
		send_idle_pct = saved_pct;
	endtask

	// Receiver: random ready, or a forced hold while hold_left runs down.
	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Compares each accepted result item with the oldest prediction.
	always @(posedge clk) begin
		queue_result_t want;
		queue_result_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.entry_valid = rsp_ch.entry_valid;
			got.entry.sig_type = rsp_ch.out_type;
			got.entry.sig_param = rsp_ch.out_param;
			got.entry.handler_id = rsp_ch.out_handler;
			got.entry.data_word = rsp_ch.out_word;
			got.overwrote = rsp_ch.overwrote;
			got.fill_count = rsp_ch.fill_count;
			if (predicted_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result: v=%0b type=%h param=%h hnd=%h word=%h ow=%0b fill=%0d",
						got.entry_valid, got.entry.sig_type, got.entry.sig_param,
						got.entry.handler_id, got.entry.data_word, got.overwrote,
						got.fill_count);
			end else begin
				want = predicted_results.pop_front();
				if (got.entry_valid !== want.entry_valid
						|| got.entry.sig_type !== want.entry.sig_type
						|| got.entry.sig_param !== want.entry.sig_param
						|| got.entry.handler_id !== want.entry.handler_id
						|| got.entry.data_word !== want.entry.data_word
						|| got.overwrote !== want.overwrote
						|| got.fill_count !== want.fill_count) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("exp: v=%0b type=%h param=%h hnd=%h word=%h ow=%0b fill=%0d",
							want.entry_valid, want.entry.sig_type, want.entry.sig_param,
							want.entry.handler_id, want.entry.data_word, want.overwrote,
							want.fill_count);
						$display("act: v=%0b type=%h param=%h hnd=%h word=%h ow=%0b fill=%0d",
							got.entry_valid, got.entry.sig_type, got.entry.sig_param,
							got.entry.handler_id, got.entry.data_word, got.overwrote,
							got.fill_count);
					end
				end
			end
		end
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#1ms;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int drain;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.command <= CMD_POP;
		req_ch.sig_type <= '0;
		req_ch.sig_param <= '0;
		req_ch.handler_id <= '0;
		req_ch.data_word <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles some, receiver idles a lot
		send_idle_pct = 32;
		recv_idle_pct = 75;
		test_directed_corners();
		test_random_traffic(350);
		test_full_backpressure();

		// and the other way round
		send_idle_pct = 75;
		recv_idle_pct = 32;
		test_random_traffic(350);

		// back to back on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(380);

		req_ch.valid <= 1'b0;
		drain = 0;
		while (predicted_results.size() != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (LATENCY_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && predicted_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/prq_pkg.sv
src/prq_ifs.sv
src/prq_ram.sv
src/prq_ctrl.sv
src/priority_ring_event_queue.sv
src/prq_checker.sv
test/tb_priority_ring_event_queue.sv
